### design/soa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int CNT_W     = 9;
  localparam int FFC_W     = 5;
  localparam int TAG_W     = 32;
  localparam int OBJ_IN_W  = 8;
  localparam int MAXF_W    = 5;
  localparam int REL_MAX   = 16;
  localparam int REL_W     = 5;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam logic [FFC_W-1:0] FFC_SAT = '1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_OBJ    = 3'd1,
    STAT_NO_SLOT   = 3'd2,
    STAT_NOT_OWNED = 3'd3,
    STAT_RELEASED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_OBJS     = 2'd0,
    REG_MAX_FREE = 2'd1,
    REG_RELEASE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ORD_NOP    = 2'd0,
    ORD_REMOVE = 2'd1,
    ORD_INSERT = 2'd2
  } ord_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SWEEP,
    ST_ALLOC_RD,
    ST_ALLOC_LINK,
    ST_LOOK_RD,
    ST_LOOK_CMP,
    ST_ORD_RD,
    ST_ORD_CMP,
    ST_POST,
    ST_REL_CHK,
    ST_REL_CMP
  } state_t;

endpackage

### design/slab_object_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator_top
// Slab allocator with slot records and object links kept in RAM.
// ----------------------------------------------------------------------------
// Usage: a command item (add page, allocate, free) is taken when start is high
// and busy is low. Each result appears for one cycle with out_valid high and
// cannot be held off; out_last marks the final result of an item. An item
// with an unknown command gives no result.
// Every item is bound by the single read port of the record RAM: allocate
//   reads the slot record, then its object link; add page sweeps the links
//   of the n objects per slab, then scans the L entries of the free-slab
//   order; free runs the page lookup over the slots and the re-placement
//   scan, plus the release scan over the order entries when it is enabled.
// No slot and no free object give one result at once; page not owned is
// reported once the page lookup has run.
// The next item is taken in the cycle the last result is shown.
// Reset clears the slot valid bits, the order list and counters; RAM
// contents are left as they are and only read once written.
// APB-style configuration: the user writes only while busy is low; not enforced.
// ----------------------------------------------------------------------------
module slab_object_allocator_top
  import soa_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int MAX_OBJS  = 256,
  parameter int PAGE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [PAGE_BITS-1:0] in_page_number,
  input  logic [OBJ_IN_W-1:0]  in_object_index,
  input  logic [TAG_W-1:0]     in_app_data,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [PAGE_BITS-1:0] out_page,
  output logic [OBJ_IN_W-1:0]  out_object,
  output logic [TAG_W-1:0]     out_tag,
  output logic                 out_last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int SW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS+1);
  localparam int LW    = $clog2(MAX_OBJS+1);
  localparam int LD    = SLOTS * MAX_OBJS;
  localparam int LAW   = LD > 1 ? $clog2(LD) : 1;
  localparam int REC_W = PAGE_BITS + TAG_W + CNT_W + LW;

  function automatic logic [LAW-1:0] lnk_addr(input logic [SW-1:0] s,
                                              input logic [LW-1:0] o);
    return LAW'(s) * LAW'(MAX_OBJS) + LAW'(o);
  endfunction

  // configuration
  logic [CNT_W-1:0]  objs_r;
  logic [MAXF_W-1:0] max_free_r;
  logic              rel_en_r;
  logic              cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      objs_r     <= CNT_W'(256);
      max_free_r <= '0;
      rel_en_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_OBJS:     objs_r     <= pwdata[CNT_W-1:0];
        REG_MAX_FREE: max_free_r <= pwdata[MAXF_W-1:0];
        REG_RELEASE:  rel_en_r   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OBJS:     prdata = DATA_W'(objs_r);
      REG_MAX_FREE: prdata = DATA_W'(max_free_r);
      REG_RELEASE:  prdata = DATA_W'(rel_en_r);
      default:      prdata = '0;
    endcase
  end

  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (objs_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(objs_r) > MAX_OBJS) begin
      n_eff = CNT_W'(MAX_OBJS);
    end else begin
      n_eff = objs_r;
    end
  end

  // state
  state_t              state_r, state_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [FFC_W-1:0]    ffc_r, ffc_nxt;
  logic                free_r, free_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [OBJ_IN_W-1:0] obj_r, obj_nxt;
  logic [LW-1:0]       head_r, head_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LW-1:0]       sweep_r, sweep_nxt;
  logic [REL_W-1:0]    rel_k_r, rel_k_nxt;

  // result register
  logic                 out_valid_r, emit;
  logic [2:0]           out_status_r, e_status;
  logic [PAGE_BITS-1:0] out_page_r, e_page;
  logic [OBJ_IN_W-1:0]  out_object_r, e_obj;
  logic [TAG_W-1:0]     out_tag_r, e_tag;
  logic                 out_last_r, e_last;

  // memories
  logic             rec_we;
  logic [SW-1:0]    rec_waddr, rec_raddr;
  logic [REC_W-1:0] rec_wdata, rec_q;
  logic             lnk_we;
  logic [LAW-1:0]   lnk_waddr, lnk_raddr;
  logic [LW-1:0]    lnk_wdata, lnk_q;

  logic [PAGE_BITS-1:0] q_page;
  logic [TAG_W-1:0]     q_tag;
  logic [CNT_W-1:0]     q_cnt;
  logic [LW-1:0]        q_head;

  assign {q_page, q_tag, q_cnt, q_head} = rec_q;

  soa_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_q)
  );

  soa_ram #(.WIDTH(LW), .DEPTH(LD)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_q)
  );

  // order list
  ord_op_t       ord_op;
  logic [CW-1:0] ord_pos, ord_count, ord_found_pos;
  logic [SW-1:0] ord_slot, ord_rd_slot, ord_head;
  logic          ord_found;

  soa_order #(.SLOTS(SLOTS)) u_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (ord_op),
    .pos       (ord_pos),
    .slot      (ord_slot),
    .rd_idx    (idx_r),
    .find      (SW'(idx_r)),
    .rd_slot   (ord_rd_slot),
    .head      (ord_head),
    .count     (ord_count),
    .found     (ord_found),
    .found_pos (ord_found_pos)
  );

  // lowest unused slot
  logic          free_hit;
  logic [SW-1:0] free_slot;
  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_hit  = 1'b1;
        free_slot = SW'(k);
      end
    end
  end

  logic [CNT_W-1:0] cnt_inc;
  assign cnt_inc = (q_cnt < CNT_SAT) ? q_cnt + CNT_W'(1) : q_cnt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    ffc_nxt   = ffc_r;
    free_nxt  = free_r;
    page_nxt  = page_r;
    tag_nxt   = tag_r;
    obj_nxt   = obj_r;
    head_nxt  = head_r;
    slot_nxt  = slot_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    sweep_nxt = sweep_r;
    rel_k_nxt = rel_k_r;
    rec_we    = 1'b0;
    rec_waddr = slot_r;
    rec_wdata = {q_page, q_tag, q_cnt, q_head};
    rec_raddr = ord_rd_slot;
    lnk_we    = 1'b0;
    lnk_waddr = lnk_addr(slot_r, sweep_r);
    lnk_wdata = '0;
    lnk_raddr = lnk_addr(slot_r, q_head);
    ord_op    = ORD_NOP;
    ord_pos   = idx_r;
    ord_slot  = slot_r;
    emit      = 1'b0;
    e_status  = STAT_OK;
    e_page    = '0;
    e_obj     = '0;
    e_tag     = '0;
    e_last    = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt = in_page_number;
          tag_nxt  = in_app_data;
          obj_nxt  = in_object_index;
          case (in_command)
            CMD_ADD: begin
              if (free_hit) begin
                rec_we    = 1'b1;
                rec_waddr = free_slot;
                rec_wdata = {in_page_number, in_app_data, n_eff, LW'(0)};
                valid_nxt[free_slot] = 1'b1;
                if (ffc_r != FFC_SAT) begin
                  ffc_nxt = ffc_r + FFC_W'(1);
                end
                slot_nxt  = free_slot;
                sweep_nxt = '0;
                free_nxt  = 1'b0;
                state_nxt = ST_ADD_SWEEP;
              end else begin
                emit     = 1'b1;
                e_status = STAT_NO_SLOT;
              end
            end
            CMD_ALLOC: begin
              if (ord_count == '0) begin
                emit     = 1'b1;
                e_status = STAT_NO_OBJ;
              end else begin
                rec_raddr = ord_head;
                slot_nxt  = ord_head;
                state_nxt = ST_ALLOC_RD;
              end
            end
            CMD_FREE: begin
              idx_nxt   = '0;
              free_nxt  = 1'b1;
              state_nxt = ST_LOOK_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // fresh slab: object list 0,1,...,n-1
      ST_ADD_SWEEP: begin
        lnk_we = 1'b1;
        if (32'(sweep_r) + 1 < 32'(n_eff)) begin
          lnk_wdata = sweep_r + LW'(1);
          sweep_nxt = sweep_r + LW'(1);
        end else begin
          lnk_wdata = LW'(MAX_OBJS);
          cnt_nxt   = n_eff;
          idx_nxt   = '0;
          state_nxt = ST_ORD_RD;
        end
      end

      ST_ALLOC_RD: begin
        if (32'(q_head) >= MAX_OBJS) begin
          emit      = 1'b1;
          e_status  = STAT_NO_OBJ;
          state_nxt = ST_IDLE;
        end else begin
          lnk_raddr = lnk_addr(slot_r, q_head);
          head_nxt  = q_head;
          page_nxt  = q_page;
          tag_nxt   = q_tag;
          cnt_nxt   = q_cnt;
          state_nxt = ST_ALLOC_LINK;
        end
      end

      ST_ALLOC_LINK: begin
        rec_we    = 1'b1;
        rec_wdata = {page_r, tag_r, (cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r, lnk_q};
        if (cnt_r == n_eff && ffc_r != '0) begin
          ffc_nxt = ffc_r - FFC_W'(1);
        end
        if (32'(lnk_q) >= MAX_OBJS) begin
          ord_op  = ORD_REMOVE;
          ord_pos = '0;
        end
        emit      = 1'b1;
        e_page    = page_r;
        e_obj     = OBJ_IN_W'(head_r);
        state_nxt = ST_IDLE;
      end

      ST_LOOK_RD: begin
        if (32'(idx_r) >= SLOTS) begin
          emit      = 1'b1;
          e_status  = STAT_NOT_OWNED;
          state_nxt = ST_IDLE;
        end else begin
          rec_raddr = SW'(idx_r);
          state_nxt = ST_LOOK_CMP;
        end
      end

      ST_LOOK_CMP: begin
        if (valid_r[SW'(idx_r)] && q_page == page_r) begin
          if (32'(obj_r) >= 32'(n_eff)) begin
            emit      = 1'b1;
            e_status  = STAT_NOT_OWNED;
            state_nxt = ST_IDLE;
          end else begin
            // push the object onto the slab list
            lnk_we    = 1'b1;
            lnk_waddr = lnk_addr(SW'(idx_r), LW'(obj_r));
            lnk_wdata = q_head;
            rec_we    = 1'b1;
            rec_waddr = SW'(idx_r);
            rec_wdata = {q_page, q_tag, cnt_inc, LW'(obj_r)};
            cnt_nxt   = cnt_inc;
            slot_nxt  = SW'(idx_r);
            if (ord_found) begin
              ord_op  = ORD_REMOVE;
              ord_pos = ord_found_pos;
              idx_nxt = ord_found_pos;
            end else begin
              idx_nxt = '0;
            end
            state_nxt = ST_ORD_RD;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_LOOK_RD;
        end
      end

      // place slab before the first later entry with count >= its own
      ST_ORD_RD: begin
        if (idx_r >= ord_count) begin
          ord_op    = ORD_INSERT;
          state_nxt = ST_POST;
        end else begin
          state_nxt = ST_ORD_CMP;
        end
      end

      ST_ORD_CMP: begin
        if (q_cnt < cnt_r) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_ORD_RD;
        end else begin
          ord_op    = ORD_INSERT;
          state_nxt = ST_POST;
        end
      end

      ST_POST: begin
        if (free_r && cnt_r == n_eff) begin
          if (ffc_r != FFC_SAT) begin
            ffc_nxt = ffc_r + FFC_W'(1);
          end
          if (rel_en_r) begin
            idx_nxt   = '0;
            rel_k_nxt = '0;
            state_nxt = ST_REL_CHK;
          end else begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_REL_CHK: begin
        if (32'(ffc_r) > 32'(max_free_r) && 32'(rel_k_r) < REL_MAX &&
            idx_r < ord_count) begin
          state_nxt = ST_REL_CMP;
        end else begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_REL_CMP: begin
        if (q_cnt == n_eff) begin
          ord_op    = ORD_REMOVE;
          valid_nxt[ord_rd_slot] = 1'b0;
          ffc_nxt   = ffc_r - FFC_W'(1);
          emit      = 1'b1;
          e_status  = STAT_RELEASED;
          e_page    = q_page;
          e_tag     = q_tag;
          e_last    = 1'b0;
          rel_k_nxt = rel_k_r + REL_W'(1);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
        state_nxt = ST_REL_CHK;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ffc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ffc_r       <= ffc_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    free_r       <= free_nxt;
    page_r       <= page_nxt;
    tag_r        <= tag_nxt;
    obj_r        <= obj_nxt;
    head_r       <= head_nxt;
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    sweep_r      <= sweep_nxt;
    rel_k_r      <= rel_k_nxt;
    out_status_r <= e_status;
    out_page_r   <= e_page;
    out_object_r <= e_obj;
    out_tag_r    <= e_tag;
    out_last_r   <= e_last;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_page   = out_page_r;
  assign out_object = out_object_r;
  assign out_tag    = out_tag_r;
  assign out_last   = out_last_r;

  a_rel_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STAT_RELEASED |-> !out_last_r)
    else $error("release result marked last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> state_r == ST_IDLE)
    else $error("block still busy after last result");

  a_rel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REL_CMP |-> idx_r < ord_count)
    else $error("release scan beyond order list");

  a_full_add_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && start && in_command == CMD_ADD && !free_hit
    |=> ord_count == $past(ord_count) && valid_r == $past(valid_r))
    else $error("failed add changed state");

endmodule

### design/soa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/soa_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_order
// Free-slab order list: slot ids kept in shift registers with remove/insert.
// ----------------------------------------------------------------------------
module soa_order
  import soa_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  ord_op_t                                    op,
  input  logic [$clog2(SLOTS+1)-1:0]                 pos,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot,
  input  logic [$clog2(SLOTS+1)-1:0]                 rd_idx,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] find,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_slot,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] head,
  output logic [$clog2(SLOTS+1)-1:0]                 count,
  output logic                                       found,
  output logic [$clog2(SLOTS+1)-1:0]                 found_pos
);

  localparam int SW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS+1);

  logic [SW-1:0] ent_r   [SLOTS];
  logic [SW-1:0] ent_nxt [SLOTS];
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    ent_nxt   = ent_r;
    count_nxt = count_r;
    unique case (op)
      ORD_REMOVE: begin
        for (int k = 0; k < SLOTS - 1; k++) begin
          if (32'(k) >= 32'(pos)) begin
            ent_nxt[k] = ent_r[k+1];
          end
        end
        count_nxt = count_r - CW'(1);
      end
      ORD_INSERT: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (32'(k) > 32'(pos)) begin
            ent_nxt[k] = ent_r[(k > 0) ? k - 1 : 0];
          end else if (32'(k) == 32'(pos)) begin
            ent_nxt[k] = slot;
          end
        end
        count_nxt = count_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // parallel match, lowest position wins
  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (32'(k) < 32'(count_r) && ent_r[k] == find) begin
        found     = 1'b1;
        found_pos = CW'(k);
      end
    end
  end

  assign rd_slot = ent_r[rd_idx[SW-1:0]];
  assign head    = ent_r[0];
  assign count   = count_r;

endmodule
